// ===== sv/deq_pkg.sv =====
// shared types and codes for the double-ended queue core
package deq_pkg;

    localparam int WORD_W   = 32;
    localparam int REQ_W    = 2;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PEEK   = 2'd2;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // sequencer states
    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_OUT
    } t_state;

    // commands from the controller to the datapath
    typedef struct packed {
        logic latch;
        logic exec;
    } t_cmd;

endpackage

// ===== sv/deq_ctrl.sv =====
// request sequencer for the double-ended queue core
module deq_ctrl (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    output logic        o_valid,
    input  logic        i_ready,
    output deq_pkg::t_cmd o_cmd
);
    import deq_pkg::*;

    t_state r_state;
    t_state n_state;

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and commands
    always_comb begin
        n_state     = r_state;
        o_cmd.latch = 1'b0;
        o_cmd.exec  = 1'b0;
        o_ready     = 1'b0;
        o_valid     = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_OUT;
            end
            S_OUT: begin
                o_valid = 1'b1;
                if (i_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/deq_datapath.sv =====
// entry store, pointers and result registers of the double-ended queue core
module deq_datapath #(
    parameter int DEPTH = 16,
    parameter int PW    = $clog2(DEPTH),
    parameter int CW    = $clog2(DEPTH + 1)
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  deq_pkg::t_cmd                  i_cmd,
    input  logic [deq_pkg::REQ_W-1:0]      i_req_type,
    input  logic                           i_at_back,
    input  logic signed [deq_pkg::WORD_W-1:0] i_word_in,
    output logic signed [deq_pkg::WORD_W-1:0] o_word_out,
    output logic [deq_pkg::STATUS_W-1:0]   o_status,
    output logic [CW-1:0]                  o_entry_count
);
    import deq_pkg::*;

    localparam logic [CW:0]   DEPTH_S = (CW + 1)'(DEPTH);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [PW-1:0] LAST_P  = PW'(DEPTH - 1);

    // latched request
    logic [REQ_W-1:0]        r_req;
    logic                    r_back;
    logic [WORD_W-1:0]       r_word;

    // queue state
    logic [PW-1:0]           r_head;
    logic [CW-1:0]           r_count;
    logic [PW-1:0]           n_head;
    logic [CW-1:0]           n_count;

    // result
    logic [WORD_W-1:0]       r_res_word;
    logic [STATUS_W-1:0]     r_res_status;
    logic                    r_use_mem;
    logic [WORD_W-1:0]       n_res_word;
    logic [STATUS_W-1:0]     n_res_status;
    logic                    n_use_mem;

    // memory
    logic [WORD_W-1:0]       r_mem [DEPTH];
    logic [WORD_W-1:0]       r_rd_data;
    logic                    w_we;
    logic                    w_re;
    logic [PW-1:0]           w_addr;

    logic                    w_full;
    logic                    w_empty;
    logic [CW:0]             w_tail_sum;
    logic [CW:0]             w_back_sum;
    logic [PW-1:0]           w_tail;
    logic [PW-1:0]           w_back_idx;
    logic [PW-1:0]           w_head_dec;
    logic [PW-1:0]           w_head_inc;

    // capture the request
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_req  <= i_req_type;
            r_back <= i_at_back;
            r_word <= i_word_in;
        end
    end

    // circular index arithmetic
    assign w_full     = (r_count == DEPTH_C);
    assign w_empty    = (r_count == '0);
    assign w_tail_sum = (CW + 1)'(r_head) + {1'b0, r_count};
    assign w_back_sum = (CW + 1)'(r_head) + {1'b0, r_count - 1'b1};
    assign w_tail     = (w_tail_sum >= DEPTH_S) ? PW'(w_tail_sum - DEPTH_S) : PW'(w_tail_sum);
    assign w_back_idx = (w_back_sum >= DEPTH_S) ? PW'(w_back_sum - DEPTH_S) : PW'(w_back_sum);
    assign w_head_dec = (r_head == '0) ? LAST_P : r_head - 1'b1;
    assign w_head_inc = (r_head == LAST_P) ? '0 : r_head + 1'b1;

    // decode the request
    always_comb begin
        n_head       = r_head;
        n_count      = r_count;
        n_res_word   = '0;
        n_res_status = ST_OK;
        n_use_mem    = 1'b0;
        w_we         = 1'b0;
        w_re         = 1'b0;
        w_addr       = r_back ? w_back_idx : r_head;
        case (r_req)
            REQ_INSERT: begin
                n_res_word = r_word;
                if (w_full) begin
                    n_res_status = ST_FULL;
                end else begin
                    w_we    = 1'b1;
                    n_count = r_count + 1'b1;
                    if (r_back) begin
                        w_addr = w_tail;
                    end else begin
                        w_addr = w_head_dec;
                        n_head = w_head_dec;
                    end
                end
            end
            REQ_REMOVE, REQ_PEEK: begin
                if (w_empty) begin
                    n_res_status = ST_EMPTY;
                end else begin
                    w_re      = 1'b1;
                    n_use_mem = 1'b1;
                    if (r_req == REQ_REMOVE) begin
                        n_count = r_count - 1'b1;
                        if (!r_back) begin
                            n_head = w_head_inc;
                        end
                    end
                end
            end
            default: begin
                n_res_status = ST_OK;
            end
        endcase
    end

    // pointer and count registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head  <= '0;
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    // result registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_res_word   <= n_res_word;
            r_res_status <= n_res_status;
            r_use_mem    <= n_use_mem;
        end
    end

    // entry store with registered read
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && w_we) begin
            r_mem[w_addr] <= r_word;
        end
        if (i_cmd.exec && w_re) begin
            r_rd_data <= r_mem[w_addr];
        end
    end

    // result item
    assign o_word_out    = r_use_mem ? r_rd_data : r_res_word;
    assign o_status      = r_res_status;
    assign o_entry_count = r_count;

endmodule

// ===== sv/double_ended_queue_core.sv =====
// top level of the double-ended queue core
// A bounded double-ended queue of signed 32-bit words held in a circular store.
// Input channel (i_valid / o_ready) carries one request item: req_type selects
// insert, remove or peek, at_back picks the end, word_in is the word to insert.
// Output channel (o_valid / i_ready) returns one result item per request: the
// removed or peeked word (insert echoes its word), a status code and the entry
// count after the request. A full insert is dropped with status full; a remove
// or peek on an empty queue gives word 0 and status empty.
// After the accepting edge the sequencer passes through its execute state,
// which updates the pointers and reads the store into a register, then it
// raises o_valid. The sequencer runs each request through the single store
// port in turn and takes no new item before the last result item is taken.
// While the result item waits for i_ready the block holds it and takes no new
// item. Reset (i_rst_n low, synchronous) empties the queue and sets the head to
// zero; store contents are not cleared and need no clearing pass.
module double_ended_queue_core #(
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_ready,
    input  logic [deq_pkg::REQ_W-1:0]            i_req_type,
    input  logic                                 i_at_back,
    input  logic signed [deq_pkg::WORD_W-1:0]    i_word_in,
    output logic                                 o_valid,
    input  logic                                 i_ready,
    output logic signed [deq_pkg::WORD_W-1:0]    o_word_out,
    output logic [deq_pkg::STATUS_W-1:0]         o_status,
    output logic [$clog2(DEPTH + 1)-1:0]         o_entry_count
);
    import deq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_cmd w_cmd;

    // sequencer
    deq_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_cmd   (w_cmd)
    );

    // store and pointers
    deq_datapath #(
        .DEPTH (DEPTH),
        .PW    ($clog2(DEPTH)),
        .CW    (CW)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_req_type    (i_req_type),
        .i_at_back     (i_at_back),
        .i_word_in     (i_word_in),
        .o_word_out    (o_word_out),
        .o_status      (o_status),
        .o_entry_count (o_entry_count)
    );

endmodule
